FILE: hdl/xtrc_pkg.sv
package xtrc_pkg;

    localparam int KEY_BITS_DEF = 16;
    localparam int VAL_W = 16;
    localparam int CNT_W = 32;
    localparam int CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_XOR    = 2'd1,
        CMD_RANK   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INSERT,
        ST_QUERY,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic ins;
        logic add;
        logic first;
        logic last;
        logic clr;
    } walk_ctl_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

FILE: hdl/xtrc_ram.sv
module xtrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/xtrc_ctrl.sv
module xtrc_ctrl
    import xtrc_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CMD_W-1:0]    command,
    input  logic [VAL_W-1:0]    key_value,
    input  logic [VAL_W-1:0]    multiplicity,
    output logic                busy,
    output walk_ctl_t           ctl,
    output logic [KEY_BITS:0]   addr,
    output logic [VAL_W-1:0]    mult
);

    localparam int NODE_W = KEY_BITS + 1;
    localparam logic [NODE_W-1:0] NODE_ROOT = NODE_W'(1);
    localparam logic [NODE_W-1:0] LAST_INS = NODE_W'(KEY_BITS);
    localparam logic [NODE_W-1:0] LAST_QRY = NODE_W'(KEY_BITS - 1);

    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   cnt_reg, cnt_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [KEY_BITS-1:0] path_reg, path_next;
    logic [KEY_BITS-1:0] smask_reg, smask_next;
    logic [KEY_BITS-1:0] mask_reg, mask_next;
    logic [VAL_W-1:0]    mult_reg, mult_next;
    logic [KEY_BITS-1:0] key_ext;
    logic                kbit;
    logic                mbit;

    assign key_ext = KEY_BITS'(key_value);
    assign kbit = path_reg[KEY_BITS-1];
    assign mbit = smask_reg[KEY_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        path_reg  <= path_next;
        smask_reg <= smask_next;
        mult_reg  <= mult_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        node_next  = node_reg;
        path_next  = path_reg;
        smask_next = smask_reg;
        mask_next  = mask_reg;
        mult_next  = mult_reg;
        ctl        = '0;
        addr       = node_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr  = 1'b1;
                addr     = cnt_reg;
                cnt_next = cnt_reg + NODE_W'(1);
                if (cnt_reg == {NODE_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = '0;
                    node_next  = NODE_ROOT;
                    smask_next = mask_reg;
                    unique case (cmd_t'(command))
                        CMD_INSERT:
                        begin
                            path_next  = key_ext ^ mask_reg;
                            mult_next  = multiplicity;
                            state_next = ST_INSERT;
                        end
                        CMD_XOR:
                        begin
                            mask_next = mask_reg ^ key_ext;
                        end
                        CMD_RANK:
                        begin
                            path_next  = key_ext;
                            state_next = ST_QUERY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INSERT:
            begin
                ctl.rd_en = 1'b1;
                ctl.ins   = 1'b1;
                addr      = node_reg;
                node_next = {node_reg[NODE_W-2:0], kbit};
                path_next = path_reg << 1;
                cnt_next  = cnt_reg + NODE_W'(1);
                if (cnt_reg == LAST_INS)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_QUERY:
            begin
                ctl.rd_en  = 1'b1;
                ctl.add    = kbit;
                ctl.first  = (cnt_reg == '0);
                ctl.last   = (cnt_reg == LAST_QRY);
                addr       = {node_reg[NODE_W-2:0], mbit};
                node_next  = {node_reg[NODE_W-2:0], kbit ^ mbit};
                path_next  = path_reg << 1;
                smask_next = smask_reg << 1;
                cnt_next   = cnt_reg + NODE_W'(1);
                if (cnt_reg == LAST_QRY)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign mult = mult_reg;

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!ctl.rd_en && !ctl.clr))
        else $error("memory access issued while idle");

    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr |-> (!ctl.rd_en && !ctl.ins))
        else $error("clearing pass overlaps a trie walk");

    a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.last |=> (state_reg == ST_DRAIN))
        else $error("last query read not followed by drain");

endmodule

FILE: hdl/xtrc_dp.sv
module xtrc_dp
    import xtrc_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  walk_ctl_t         ctl,
    input  logic [KEY_BITS:0] addr,
    input  logic [VAL_W-1:0]  mult,
    input  logic [CNT_W-1:0]  rd_data,
    output logic              wr_en,
    output logic [KEY_BITS:0] wr_addr,
    output logic [CNT_W-1:0]  wr_data,
    output logic [CNT_W-1:0]  rank_count,
    output logic              done
);

    logic              v_reg;
    logic              ins_reg;
    logic              add_reg;
    logic              first_reg;
    logic              last_reg;
    logic              done_reg;
    logic [KEY_BITS:0] addr_reg;
    logic [CNT_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  rank_count_reg;
    logic [CNT_W-1:0]  sum;
    logic              ins_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= 1'b0;
            ins_reg   <= 1'b0;
            add_reg   <= 1'b0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v_reg     <= ctl.rd_en;
            ins_reg   <= ctl.ins;
            add_reg   <= ctl.add;
            first_reg <= ctl.first;
            last_reg  <= ctl.last;
            done_reg  <= v_reg && !ins_reg && last_reg;
        end
    end

    assign sum = sat_add(first_reg ? '0 : acc_reg, add_reg ? rd_data : '0);

    always_ff @(posedge clk)
    begin
        addr_reg <= addr;
        if (v_reg && !ins_reg)
        begin
            acc_reg <= sum;
            if (last_reg)
            begin
                rank_count_reg <= sum;
            end
        end
    end

    assign ins_wr     = v_reg && ins_reg;
    assign wr_en      = ctl.clr || ins_wr;
    assign wr_addr    = ctl.clr ? addr : addr_reg;
    assign wr_data    = ctl.clr ? '0 : sat_add(rd_data, CNT_W'(mult));
    assign rank_count = rank_count_reg;
    assign done       = done_reg;

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(v_reg && !ins_reg && last_reg))
        else $error("result strobe without a finished query");

    a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.clr && ins_wr))
        else $error("clear write collides with insert write-back");

endmodule

FILE: hdl/xor_trie_rank_counter_core.sv
// Channel   Handshake            Payload
// command   start / busy         command, key_value, multiplicity
// result    done (one cycle)     rank_count
//
// The prefix counters live in one memory of 2 << KEY_BITS words, one read
// and one write per cycle. An insert walks KEY_BITS + 1 levels with a
// read-modify-write per level and keeps busy high through its last write-back.
// A rank query reads one node per level, keeps busy high while it walks
// and strobes done in the first cycle with busy low. A xor-all transfer
// takes effect at once and leaves busy low. After reset a clearing pass
// zeroes all 2 << KEY_BITS words with busy high. Results cannot be stalled.
module xor_trie_rank_counter_core
    import xtrc_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] command,
    input  logic [VAL_W-1:0] key_value,
    input  logic [VAL_W-1:0] multiplicity,
    output logic [CNT_W-1:0] rank_count,
    output logic             done
);

    localparam int DEPTH = 2 << KEY_BITS;

    walk_ctl_t         ctl;
    logic [KEY_BITS:0] addr;
    logic [VAL_W-1:0]  mult;
    logic [CNT_W-1:0]  rd_data;
    logic              wr_en;
    logic [KEY_BITS:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;

    xtrc_ctrl #(
        .KEY_BITS(KEY_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .key_value    (key_value),
        .multiplicity (multiplicity),
        .busy         (busy),
        .ctl          (ctl),
        .addr         (addr),
        .mult         (mult)
    );

    xtrc_ram #(
        .WIDTH(CNT_W),
        .DEPTH(DEPTH)
    ) u_counts (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    xtrc_dp #(
        .KEY_BITS(KEY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .addr       (addr),
        .mult       (mult),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rank_count (rank_count),
        .done       (done)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import xtrc_pkg::*;

    localparam int KEY_W = KEY_BITS_DEF;
    localparam int NODES = 2 << KEY_W;
    localparam int QUIET_LIMIT = 4 * NODES;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0] op;
        logic [VAL_W-1:0] key;
        logic [VAL_W-1:0] copies;
        int unsigned      gap;
        bit               settle;
    } order_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [CMD_W-1:0] command = '0;
    logic [VAL_W-1:0] key_value = '0;
    logic [VAL_W-1:0] multiplicity = '0;
    logic [CNT_W-1:0] rank_count;
    logic             done;

    order_t            orders[$];
    order_t            cur;
    bit [CNT_W-1:0]    rank_pending[$];
    bit [CNT_W-1:0]    node_count[0:NODES-1];
    bit [VAL_W-1:0]    mask_now;
    bit                presenting;
    bit                armed;
    bit                took;
    int unsigned       gap_left;
    int unsigned       n_accepted;
    int unsigned       n_ranks;
    int unsigned       n_errors;
    int unsigned       quiet;

    xor_trie_rank_counter_core #(
        .KEY_BITS(KEY_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .key_value(key_value),
        .multiplicity(multiplicity),
        .rank_count(rank_count),
        .done(done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit [CNT_W-1:0] add_clamped(bit [CNT_W-1:0] a, bit [CNT_W-1:0] b);
        bit [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    task automatic trie_add(input bit [VAL_W-1:0] key, input bit [VAL_W-1:0] copies);
        bit [VAL_W-1:0] path;
        int unsigned    node;
        path = key ^ mask_now;
        node = 1;
        node_count[node] = add_clamped(node_count[node], copies);
        for (int lvl = KEY_W - 1; lvl >= 0; lvl--)
        begin
            node = (node << 1) | path[lvl];
            node_count[node] = add_clamped(node_count[node], copies);
        end
    endtask

    function automatic bit [CNT_W-1:0] count_below(bit [VAL_W-1:0] key);
        int unsigned    node;
        int unsigned    base;
        bit [CNT_W-1:0] total;
        node = 1;
        total = '0;
        for (int lvl = KEY_W - 1; lvl >= 0; lvl--)
        begin
            base = node << 1;
            if (key[lvl])
            begin
                total = add_clamped(total, node_count[base | mask_now[lvl]]);
            end
            node = base | (key[lvl] ^ mask_now[lvl]);
        end
        return total;
    endfunction

    task automatic push_order(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] key,
                              input logic [VAL_W-1:0] copies, input int unsigned gap,
                              input bit settle);
        order_t o;
        o.op = op;
        o.key = key;
        o.copies = copies;
        o.gap = gap;
        o.settle = settle;
        orders.push_back(o);
    endtask

    // Transfers are counted and predicted at the rising edge that accepts them.
    always @(posedge clk)
    begin
        bit accept;
        bit [CNT_W-1:0] want;
        accept = rst_n && start && !busy;
        took <= accept;
        if (accept)
        begin
            n_accepted++;
            if (command == CMD_INSERT)
            begin
                trie_add(key_value, multiplicity);
            end
            else if (command == CMD_XOR)
            begin
                mask_now ^= key_value;
            end
            else if (command == CMD_RANK)
            begin
                rank_pending.push_back(count_below(key_value));
            end
        end
        if (rst_n && done)
        begin
            if (rank_pending.size() == 0)
            begin
                $error("rank_count: unexpected result %0d", rank_count);
                n_errors++;
            end
            else
            begin
                want = rank_pending.pop_front();
                n_ranks++;
                if (rank_count !== want)
                begin
                    $error("rank_count mismatch: expected %0d, actual %0d", want, rank_count);
                    n_errors++;
                end
            end
        end
        if (accept || (rst_n && done))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d cycles with no transfer", quiet);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took)
            begin
                presenting = 1'b0;
            end
            if (!presenting && orders.size() > 0)
            begin
                if (!armed)
                begin
                    gap_left = orders[0].gap;
                    armed = 1'b1;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (!(orders[0].settle && rank_pending.size() > 0))
                begin
                    cur = orders.pop_front();
                    presenting = 1'b1;
                    armed = 1'b0;
                end
            end
            if (presenting)
            begin
                command <= cur.op;
                key_value <= cur.key;
                multiplicity <= cur.copies;
            end
            else
            begin
                command <= CMD_W'($urandom());
                key_value <= VAL_W'($urandom());
                multiplicity <= VAL_W'($urandom());
            end
            start <= presenting;
        end
    end

    initial
    begin
        int unsigned made;
        int unsigned r;
        bit          calm;
        logic [CMD_W-1:0] op;
        logic [VAL_W-1:0] key;
        logic [VAL_W-1:0] copies;

        push_order(CMD_RANK, 16'h0000, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'hFFFF, 16'hFFFF, $urandom_range(0, 6), 1'b0);
        push_order(CMD_INSERT, 16'h0000, 16'h0001, $urandom_range(0, 6), 1'b0);
        push_order(CMD_INSERT, 16'hFFFF, 16'hFFFF, $urandom_range(0, 6), 1'b0);
        push_order(CMD_INSERT, 16'h1234, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_UNUSED, 16'h5555, 16'h0007, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'hFFFF, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'h0000, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'h0001, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'h1235, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_XOR, 16'hFFFF, 16'hFFFF, $urandom_range(0, 6), 1'b1);
        push_order(CMD_RANK, 16'h0000, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'hFFFF, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'h8000, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_INSERT, 16'h8000, 16'h0003, $urandom_range(0, 6), 1'b0);
        push_order(CMD_XOR, 16'hAAAA, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'h5555, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'hAAAA, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_XOR, 16'h5555, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'h8000, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_INSERT, 16'h7FFF, 16'h0001, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'hFFFF, 16'h0000, $urandom_range(0, 6), 1'b0);

        made = 0;
        calm = 1'b0;
        while (made < 1620)
        begin
            if (made % 60 == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                op = CMD_INSERT;
            end
            else if (r < 55)
            begin
                op = CMD_XOR;
            end
            else if (r < 95)
            begin
                op = CMD_RANK;
            end
            else
            begin
                op = CMD_UNUSED;
            end
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                key = '0;
            end
            else if (r == 1)
            begin
                key = '1;
            end
            else if (r == 2)
            begin
                key = 16'h0001 << $urandom_range(0, VAL_W - 1);
            end
            else
            begin
                key = VAL_W'($urandom());
            end
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                copies = '0;
            end
            else if (r == 1)
            begin
                copies = '1;
            end
            else if (r < 4)
            begin
                copies = VAL_W'($urandom_range(1, 15));
            end
            else
            begin
                copies = VAL_W'($urandom());
            end
            push_order(op, key, copies, calm ? 0 : $urandom_range(0, 6),
                       ($urandom_range(0, 49) == 0));
            made++;
        end

        push_order(CMD_INSERT, 16'hFFFF, 16'h0005, 0, 1'b1);
        push_order(CMD_RANK, 16'h0001, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'hFFFF, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_RANK, 16'h8000, 16'h0000, $urandom_range(0, 6), 1'b0);
        push_order(CMD_XOR, VAL_W'($urandom()), 16'h0000, $urandom_range(0, 6), 1'b0);
        for (int i = 0; i < 6; i++)
        begin
            push_order(CMD_RANK, VAL_W'($urandom()), 16'h0000, $urandom_range(0, 6), 1'b0);
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        while (orders.size() > 0 || presenting)
        begin
            @(negedge clk);
        end
        while (rank_pending.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (2 * KEY_W + 8) @(negedge clk);

        $display("Accepted %0d transfers and checked %0d rank results,", n_accepted, n_ranks);
        $display("mixing inserts, mask changes, unused commands and idle gaps of 0 to 6 cycles.");
        if (n_errors == 0 && rank_pending.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
